// ----- hw/rtl/rdae_pkg.sv -----
// ----------------------------------------------------------------------------
// rdae_pkg
// Shared types, constants and the plane address mapping for the row-group
// window capture and pixel descrambler.
// ----------------------------------------------------------------------------
package rdae_pkg;

  // data lines and pixel geometry
  localparam int unsigned LANES       = 44;
  localparam int unsigned PIXELS      = 224;
  localparam int unsigned GAIN_BITS   = 2;
  localparam int unsigned FINE_BITS   = 8;
  localparam int unsigned COARSE_BITS = 5;
  localparam int unsigned PLANES      = GAIN_BITS + FINE_BITS + COARSE_BITS;
  localparam int unsigned DEPTH       = PLANES * PIXELS;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned PLANE_W     = $clog2(PLANES);
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned LANE_W      = 6;
  localparam int unsigned CODE_W      = PLANES;

  // sample counter
  localparam int unsigned CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration registers
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned START_W    = 16;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned WIN_W      = CNT_W + 1;

  localparam logic [START_W-1:0]  START_RST  = START_W'(9962);
  localparam logic [SEL_W-1:0]    SEL_RST    = '0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(3360);

  typedef enum logic [1:0] {
    REG_CAPTURE_START = 2'd0,
    REG_BLOCK_SELECT  = 2'd1,
    REG_WINDOW_LENGTH = 2'd2
  } cfg_reg_e;

  // stream field positions
  localparam int unsigned S_DATA_W  = 64;
  localparam int unsigned S_USER_W  = 2;
  localparam int unsigned PIX_LSB   = LANES;
  localparam int unsigned LANE_LSB  = LANES + PIX_W;
  localparam int unsigned USER_TYPE = 0;
  localparam int unsigned USER_FIRST = 1;
  localparam int unsigned M_DATA_W  = 16;

  // memory ports
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LANES-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  // reader sequencer
  typedef enum logic [1:0] {
    RD_IDLE,
    RD_FETCH,
    RD_LAST,
    RD_DONE
  } rd_state_e;

  // store address of one plane bit of a pixel
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [PLANE_W-1:0] plane,
                                                  input logic [PIX_W-1:0]   pix);
    logic [1:0]        k;
    logic [2:0]        s;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] grp;
    logic [ADDR_W-1:0] col;
    k = pix[4:3];
    // last 8 of 32 pixels read slot 0; first group shifts by one, not in plane 0
    if (k == 2'd3) begin
      s = 3'd0;
    end else if ((plane != '0) && (pix[PIX_W-1:5] == '0)) begin
      s = 3'(k) + 3'd2;
    end else begin
      s = 3'(k) + 3'd1;
    end
    base = ADDR_W'(plane) * ADDR_W'(PIXELS);
    grp  = ADDR_W'(pix[PIX_W-1:5]) << 2;
    col  = ADDR_W'(3'd7 - pix[2:0]) * ADDR_W'(28);
    return base + grp + col + ADDR_W'(s);
  endfunction

endpackage

// ----- hw/rtl/rdae_frame_mem.sv -----
// ----------------------------------------------------------------------------
// rdae_frame_mem
// Window store: one write port for captured samples, one registered read
// port for plane fetches.
// ----------------------------------------------------------------------------
module rdae_frame_mem
  import rdae_pkg::*;
(
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  mem_rd_t          rd_i,
  output logic [LANES-1:0] rdata_o
);

  logic [LANES-1:0] mem [DEPTH];
  logic [LANES-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rdae_capture.sv -----
// ----------------------------------------------------------------------------
// rdae_capture
// Sample counter, window registers and window write path into the store.
// ----------------------------------------------------------------------------
module rdae_capture
  import rdae_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  sample_i,
  input  logic                  first_i,
  input  logic [LANES-1:0]      word_i,
  output mem_wr_t               wr_o,
  output logic                  complete_o
);

  logic [START_W-1:0]  start_q, start_d;
  logic [SEL_W-1:0]    sel_q, sel_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                complete_q, complete_d;

  logic [CNT_W-1:0]    cnt_eff;
  logic [WIN_W-1:0]    win_start;
  logic [WIN_W-1:0]    offset;
  logic                in_win;

  // register writes
  always_comb begin
    start_d  = start_q;
    sel_d    = sel_q;
    stride_d = stride_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPTURE_START: start_d  = cfg_data_i[START_W-1:0];
        REG_BLOCK_SELECT:  sel_d    = cfg_data_i[SEL_W-1:0];
        REG_WINDOW_LENGTH: stride_d = cfg_data_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // window position of the current sample
  assign cnt_eff   = first_i ? '0 : cnt_q;
  assign win_start = WIN_W'(start_q) + (WIN_W'(sel_q) * WIN_W'(stride_q));
  assign offset    = WIN_W'(cnt_eff) - win_start;
  assign in_win    = (cnt_eff != CNT_MAX) && (WIN_W'(cnt_eff) >= win_start)
                     && (offset < WIN_W'(DEPTH));

  // counter and completion flag
  always_comb begin
    cnt_d      = cnt_q;
    complete_d = complete_q;
    if (sample_i) begin
      if (first_i) begin
        complete_d = 1'b0;
      end
      if (in_win && (offset == WIN_W'(DEPTH - 1))) begin
        complete_d = 1'b1;
      end
      cnt_d = (cnt_eff == CNT_MAX) ? CNT_MAX : cnt_eff + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= START_RST;
      sel_q      <= SEL_RST;
      stride_q   <= STRIDE_RST;
      cnt_q      <= '0;
      complete_q <= 1'b0;
    end else begin
      start_q    <= start_d;
      sel_q      <= sel_d;
      stride_q   <= stride_d;
      cnt_q      <= cnt_d;
      complete_q <= complete_d;
    end
  end

  // store write
  assign wr_o.en     = sample_i && in_win;
  assign wr_o.addr   = offset[ADDR_W-1:0];
  assign wr_o.data   = word_i;
  assign complete_o  = complete_q;

endmodule

// ----- hw/rtl/rdae_reader.sv -----
// ----------------------------------------------------------------------------
// rdae_reader
// Read request sequencer: fetches the planes of one pixel from the store,
// assembles the codes and holds the result beat.
// ----------------------------------------------------------------------------
module rdae_reader
  import rdae_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_i,
  input  logic [PIX_W-1:0]  pix_i,
  input  logic [LANE_W-1:0] lane_i,
  input  logic              complete_i,
  input  logic [LANES-1:0]  rdata_i,
  output mem_rd_t           rd_o,
  output logic              idle_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic              out_frame_o
);

  rd_state_e          state_q, state_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [PIX_W-1:0]   pix_q, pix_d;
  logic [LANE_W-1:0]  lane_q, lane_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic               frame_q, frame_d;
  logic               pend_q;
  logic               ovalid_q, ovalid_d;
  logic [CODE_W-1:0]  ocode_q;
  logic               oframe_q;

  logic               eligible;
  logic               fetch;
  logic               load;
  logic               slot_free;

  assign eligible  = complete_i && (pix_i < PIX_W'(PIXELS)) && (lane_i < LANE_W'(LANES));
  assign slot_free = !ovalid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RD_IDLE:  if (req_i) state_d = eligible ? RD_FETCH : RD_DONE;
      RD_FETCH: if (plane_q == PLANE_W'(PLANES - 1)) state_d = RD_LAST;
      RD_LAST:  state_d = RD_DONE;
      RD_DONE:  if (slot_free) state_d = RD_IDLE;
      default:  state_d = RD_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    idle_o = 1'b0;
    fetch  = 1'b0;
    load   = 1'b0;
    unique case (state_q)
      RD_IDLE:  idle_o = 1'b1;
      RD_FETCH: fetch  = 1'b1;
      RD_LAST:  ;
      RD_DONE:  load   = slot_free;
      default:  ;
    endcase
  end

  // request capture, plane counter and bit assembly
  always_comb begin
    plane_d = plane_q;
    pix_d   = pix_q;
    lane_d  = lane_q;
    frame_d = frame_q;
    code_d  = code_q;
    if (idle_o && req_i) begin
      pix_d   = pix_i;
      lane_d  = lane_i;
      frame_d = complete_i;
      plane_d = '0;
      code_d  = '0;
    end else begin
      if (fetch) begin
        plane_d = plane_q + 1'b1;
      end
      if (pend_q) begin
        code_d = {code_q[CODE_W-2:0], rdata_i[lane_q]};
      end
    end
  end

  assign rd_o.en   = fetch;
  assign rd_o.addr = slot_addr(plane_q, pix_q);

  // result register
  assign ovalid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= RD_IDLE;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= fetch;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
    pix_q   <= pix_d;
    lane_q  <= lane_d;
    frame_q <= frame_d;
    code_q  <= code_d;
    if (load) begin
      ocode_q  <= code_q;
      oframe_q <= frame_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_code_o  = ocode_q;
  assign out_frame_o = oframe_q;

endmodule

// ----- hw/rtl/rowgroup_descramble_adc_extract.sv -----
// ----------------------------------------------------------------------------
// rowgroup_descramble_adc_extract
// Captures one window of readout samples and reads back descrambled pixel
// gain, fine and coarse codes for a chosen pixel and data line.
// ----------------------------------------------------------------------------
// Sample beats are taken one per clock while the reader is idle, and written
// straight into a 3360-word store at their offset in the selected window. A
// read request beat occupies the block: when the window is complete, the 15
// planes of the pixel are fetched one per cycle through the store's single
// read port, and the codes leave through an output register, so the next beat
// is taken as soon as that register is free or drained. A request while the
// window is incomplete, or for a pixel or line out of range, returns zero
// codes. frame_ready on tuser tells whether the window was complete.
// ----------------------------------------------------------------------------
module rowgroup_descramble_adc_extract
  import rdae_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_word[43:0], pixel_index[51:44], lane_index[57:52], zero[63:58]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // req_type[0], first_sample[1]
  input  logic [S_USER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // gain_code[1:0], fine_code[9:2], coarse_code[14:10], zero[15]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // frame_ready[0]
  output logic                  m_axis_tuser
);

  mem_wr_t           wr;
  mem_rd_t           rd;
  logic [LANES-1:0]  rdata;
  logic              complete;
  logic              idle;
  logic              beat;
  logic              sample_beat;
  logic              req_beat;
  logic [CODE_W-1:0] code;

  // input beat decode
  assign s_axis_tready = idle;
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign sample_beat   = beat && !s_axis_tuser[USER_TYPE];
  assign req_beat      = beat && s_axis_tuser[USER_TYPE];

  rdae_capture u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_beat),
    .first_i    (s_axis_tuser[USER_FIRST]),
    .word_i     (s_axis_tdata[LANES-1:0]),
    .wr_o       (wr),
    .complete_o (complete)
  );

  rdae_frame_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  rdae_reader u_reader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_beat),
    .pix_i       (s_axis_tdata[PIX_LSB +: PIX_W]),
    .lane_i      (s_axis_tdata[LANE_LSB +: LANE_W]),
    .complete_i  (complete),
    .rdata_i     (rdata),
    .rd_o        (rd),
    .idle_o      (idle),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (code),
    .out_frame_o (m_axis_tuser)
  );

  // codes arrive first plane in the top bit; repack gain, fine, coarse from lsb
  assign m_axis_tdata = {1'b0,
                         code[COARSE_BITS-1:0],
                         code[COARSE_BITS +: FINE_BITS],
                         code[CODE_W-1 -: GAIN_BITS]};

endmodule
